@@ rtl/mbsp_pkg.sv @@
package mbsp_pkg;

  localparam logic [7:0] NO_MSG      = 8'h00;
  localparam logic [7:0] NOTE_OFF    = 8'h80;
  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam logic [7:0] POLY_PRESS  = 8'hA0;
  localparam logic [7:0] CTRL_CHANGE = 8'hB0;
  localparam logic [7:0] PROG_CHANGE = 8'hC0;
  localparam logic [7:0] CHAN_PRESS  = 8'hD0;
  localparam logic [7:0] PITCH_BEND  = 8'hE0;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] SONG_POS    = 8'hF2;
  localparam logic [7:0] SONG_SEL    = 8'hF3;
  localparam logic [7:0] UNDEF_F4    = 8'hF4;
  localparam logic [7:0] UNDEF_F5    = 8'hF5;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] UNDEF_FD    = 8'hFD;

  localparam logic [3:0] SYS_NIBBLE  = 4'hF;
  localparam logic [4:0] RT_PREFIX   = 5'b11111;
  localparam logic [4:0] OMNI        = 5'd0;

  typedef struct packed {
    logic [7:0] msg_type;
    logic [4:0] channel;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [6:0] msg_length;
    logic [7:0] sysex_byte;
    logic [5:0] sysex_position;
    logic       last;
  } msg_t;

  function automatic logic [7:0] kind_of(input logic [7:0] s);
    if (!s[7] || s == UNDEF_F4 || s == UNDEF_F5 || s == UNDEF_FD) begin
      return NO_MSG;
    end else if (s[7:4] != SYS_NIBBLE) begin
      return {s[7:4], 4'h0};
    end else begin
      return s;
    end
  endfunction

  function automatic logic is_chan(input logic [7:0] s);
    return s[7] && (s[7:4] != SYS_NIBBLE);
  endfunction

  function automatic logic is_sysex(input logic [7:0] s);
    return (s == SYSEX_START) || (s == SYSEX_END);
  endfunction

  function automatic logic is_realtime(input logic [7:0] s);
    return (s[7:3] == RT_PREFIX) && (s != UNDEF_FD);
  endfunction

  function automatic logic is_two(input logic [7:0] t);
    return (t == PROG_CHANGE) || (t == CHAN_PRESS) || (t == MTC_QFRAME) ||
           (t == SONG_SEL);
  endfunction

  function automatic logic is_three(input logic [7:0] t);
    return (t == NOTE_OFF) || (t == NOTE_ON) || (t == POLY_PRESS) ||
           (t == CTRL_CHANGE) || (t == PITCH_BEND) || (t == SONG_POS);
  endfunction

  function automatic logic [4:0] chan_of(input logic [7:0] s);
    return {1'b0, s[3:0]} + 5'd1;
  endfunction

  function automatic msg_t make_msg(input logic [7:0] t, input logic [4:0] ch,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [6:0] len);
    msg_t m;
    m.msg_type       = t;
    m.channel        = ch;
    m.data1          = d1;
    m.data2          = d2;
    m.msg_length     = len;
    m.sysex_byte     = 8'h00;
    m.sysex_position = 6'd0;
    m.last           = 1'b1;
    return m;
  endfunction

endpackage

@@ rtl/midi_byte_stream_parser.sv @@
// Each taken byte waits in the input register until the parser is idle and the output
// register is free; its result is then registered. No byte is taken while one is waiting.
// A SysEx start or end byte, or overflow, streams the chunk out of the buffer RAM, one word
// per cycle when not stalled; after overflow, S_FIX0 and S_FIX1 write F7 and the carried byte.
// Synchronous reset clears pending message, running status, channel register and handshakes;
// the SysEx buffer RAM is not cleared.
module midi_byte_stream_parser #(
  parameter int SYSEX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       msg_valid,
  input  logic       msg_stall,
  output logic [7:0] msg_type,
  output logic [4:0] channel,
  output logic [7:0] data1,
  output logic [7:0] data2,
  output logic [6:0] msg_length,
  output logic [7:0] sysex_byte,
  output logic [5:0] sysex_position,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int AW = $clog2(SYSEX_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(SYSEX_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_FIX0 = 2'd2;
  localparam logic [1:0] S_FIX1 = 2'd3;

  logic [1:0]      state, state_next;
  logic            ib_valid, ib_take;
  logic [7:0]      ib_byte;
  logic [4:0]      listen_channel;
  logic [7:0]      pstat, pstat_next;
  logic [7:0]      pdata0, pdata0_next;
  logic [AW-1:0]   pidx, pidx_next;
  logic [7:0]      rs, rs_next;
  logic [7:0]      carried, carried_next;
  logic [AW-1:0]   rd_k, rd_k_next;
  logic [AW-1:0]   rd_end, rd_end_next;
  logic [7:0]      rd_lastb, rd_lastb_next;
  logic            rd_fix, rd_fix_next;
  mbsp_pkg::msg_t  msg, msg_next;
  logic            msg_load;
  logic            out_free;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  mbsp_ram #(
    .WIDTH(8),
    .DEPTH(SYSEX_DEPTH)
  ) u_sysex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rx_stall  = ib_valid;
  assign cfg_ready = 1'b1;
  assign out_free  = !msg_valid || !msg_stall;

  assign msg_type       = msg.msg_type;
  assign channel        = msg.channel;
  assign data1          = msg.data1;
  assign data2          = msg.data2;
  assign msg_length     = msg.msg_length;
  assign sysex_byte     = msg.sysex_byte;
  assign sysex_position = msg.sysex_position;
  assign last           = msg.last;

  always_comb begin
    logic [7:0] b;
    logic [7:0] t;
    logic [7:0] s;
    logic [4:0] ch;
    logic       ch_ok;
    logic       three;
    logic       chan;

    state_next    = state;
    pstat_next    = pstat;
    pdata0_next   = pdata0;
    pidx_next     = pidx;
    rs_next       = rs;
    carried_next  = carried;
    rd_k_next     = rd_k;
    rd_end_next   = rd_end;
    rd_lastb_next = rd_lastb;
    rd_fix_next   = rd_fix;
    msg_next      = msg;
    msg_load      = 1'b0;
    ib_take       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = 8'h00;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    b     = ib_byte;
    s     = (pidx == '0) ? rs : pstat;
    t     = mbsp_pkg::kind_of(s);
    ch    = mbsp_pkg::chan_of(s);
    ch_ok = (listen_channel == mbsp_pkg::OMNI) || (listen_channel == ch);
    three = mbsp_pkg::is_three(t);
    chan  = mbsp_pkg::is_chan(s);

    unique case (state)
      S_IDLE: begin
        if (ib_valid && out_free) begin
          ib_take = 1'b1;
          if (b != mbsp_pkg::UNDEF_FD) begin
            if (pidx == '0) begin
              if (chan && !b[7]) begin
                pstat_next  = rs;
                pdata0_next = b;
                if (three) begin
                  pidx_next = AW'(2);
                end else if (ch_ok) begin
                  msg_load = 1'b1;
                  msg_next = mbsp_pkg::make_msg(t, ch, b, 8'h00, 7'd2);
                end
              end else begin
                pstat_next = b;
                if (mbsp_pkg::is_sysex(mbsp_pkg::kind_of(b))) begin
                  rs_next   = 8'h00;
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = b;
                  pidx_next = AW'(1);
                end else if (mbsp_pkg::is_two(mbsp_pkg::kind_of(b)) ||
                             mbsp_pkg::is_three(mbsp_pkg::kind_of(b))) begin
                  pidx_next = AW'(1);
                end else if (mbsp_pkg::kind_of(b) != mbsp_pkg::NO_MSG) begin
                  msg_load = 1'b1;
                  msg_next = mbsp_pkg::make_msg(mbsp_pkg::kind_of(b), 5'd0, 8'h00, 8'h00,
                                                7'd1);
                end
              end
            end else if (mbsp_pkg::is_realtime(b)) begin
              msg_load = 1'b1;
              msg_next = mbsp_pkg::make_msg(b, 5'd0, 8'h00, 8'h00, 7'd1);
            end else if (mbsp_pkg::is_sysex(b)) begin
              if (mbsp_pkg::is_sysex(pstat)) begin
                rd_k_next     = '0;
                rd_end_next   = pidx;
                rd_lastb_next = b;
                rd_fix_next   = 1'b0;
                ram_re        = 1'b1;
                ram_raddr     = '0;
                pidx_next     = '0;
                rs_next       = 8'h00;
                state_next    = S_RD;
              end
            end else if (mbsp_pkg::is_sysex(pstat)) begin
              if (pidx == LAST_IDX) begin
                rd_k_next     = '0;
                rd_end_next   = LAST_IDX;
                rd_lastb_next = mbsp_pkg::SYSEX_START;
                rd_fix_next   = 1'b1;
                carried_next  = b;
                ram_re        = 1'b1;
                ram_raddr     = '0;
                pidx_next     = AW'(2);
                state_next    = S_RD;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pidx;
                ram_wdata = b;
                pidx_next = pidx + AW'(1);
              end
            end else begin
              if (pidx == AW'(1)) begin
                pdata0_next = b;
              end
              if (pidx == (three ? AW'(2) : AW'(1))) begin
                pidx_next = '0;
                rs_next   = chan ? pstat : 8'h00;
                if (!chan || ch_ok) begin
                  msg_load = 1'b1;
                  msg_next = mbsp_pkg::make_msg(t, chan ? ch : 5'd0,
                                                (pidx == AW'(1)) ? b : pdata0,
                                                three ? b : 8'h00,
                                                three ? 7'd3 : 7'd2);
                end
              end else begin
                pidx_next = pidx + AW'(1);
              end
            end
          end
        end
      end
      S_RD: begin
        if (out_free) begin
          msg_load                = 1'b1;
          msg_next.msg_type       = mbsp_pkg::SYSEX_START;
          msg_next.channel        = 5'd0;
          msg_next.data1          = 8'h00;
          msg_next.data2          = 8'h00;
          msg_next.msg_length     = 7'(rd_end) + 7'd1;
          msg_next.sysex_byte     = (rd_k == rd_end) ? rd_lastb : ram_rdata;
          msg_next.sysex_position = 6'(rd_k);
          msg_next.last           = (rd_k == rd_end);
          if (rd_k == rd_end) begin
            state_next = rd_fix ? S_FIX0 : S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_k + AW'(1);
            rd_k_next = rd_k + AW'(1);
          end
        end
      end
      S_FIX0: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = mbsp_pkg::SYSEX_END;
        state_next = S_FIX1;
      end
      S_FIX1: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(1);
        ram_wdata  = carried;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ib_valid       <= 1'b0;
      msg_valid      <= 1'b0;
      listen_channel <= mbsp_pkg::OMNI;
      pidx           <= '0;
      rs             <= 8'h00;
      rd_k           <= '0;
      rd_end         <= '0;
      rd_fix         <= 1'b0;
    end else begin
      state  <= state_next;
      pidx   <= pidx_next;
      rs     <= rs_next;
      rd_k   <= rd_k_next;
      rd_end <= rd_end_next;
      rd_fix <= rd_fix_next;
      if (rx_valid && !rx_stall) begin
        ib_valid <= 1'b1;
      end else if (ib_take) begin
        ib_valid <= 1'b0;
      end
      if (msg_load) begin
        msg_valid <= 1'b1;
      end else if (!msg_stall) begin
        msg_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        listen_channel <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      ib_byte <= rx_byte;
    end
    if (msg_load) begin
      msg <= msg_next;
    end
    pstat    <= pstat_next;
    pdata0   <= pdata0_next;
    carried  <= carried_next;
    rd_lastb <= rd_lastb_next;
  end

  a_rd_in_chunk: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (rd_k <= rd_end))
    else $error("chunk read index past chunk end");

  a_short_pending: assert property (@(posedge clk) disable iff (rst)
    (pidx != '0 && !mbsp_pkg::is_sysex(pstat)) |-> (pidx <= AW'(2)))
    else $error("non-SysEx pending index out of range");

  a_fix_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX0) |-> ($past(state) == S_RD && $past(rd_fix)))
    else $error("buffer fixup without overflow chunk");

  a_nonlast_in_rd: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && !msg.last) |-> (state == S_RD))
    else $error("non-final word outside SysEx readout");

endmodule

@@ rtl/mbsp_ram.sv @@
module mbsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/sv/midi_byte_stream_parser_test.sv @@
`timescale 1ns / 1ps

module midi_byte_stream_parser_test;

  localparam int SX_DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [7:0] TUNE_REQ = 8'hF6;
  localparam logic [7:0] TIMING_CLK = 8'hF8;
  localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] SYS_RESET = 8'hFF;

  logic       clk;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       msg_valid;
  logic       msg_stall = 1'b0;
  logic [7:0] msg_type;
  logic [4:0] channel;
  logic [7:0] data1;
  logic [7:0] data2;
  logic [6:0] msg_length;
  logic [7:0] sysex_byte;
  logic [5:0] sysex_position;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = 5'd0;

  midi_byte_stream_parser u_top (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg_type(msg_type),
    .channel(channel),
    .data1(data1),
    .data2(data2),
    .msg_length(msg_length),
    .sysex_byte(sysex_byte),
    .sysex_position(sysex_position),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  logic [7:0]     tx_bytes[$];
  mbsp_pkg::msg_t parsed_msgs[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_on = 1'b0;
  int hold_count = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int bytes_taken = 0;
  int msgs_checked = 0;
  int sx_overflows = 0;
  int queued_total = 0;

  logic [4:0] listen_ch = mbsp_pkg::OMNI;
  logic [7:0] cur_status = 8'h00;
  logic [7:0] cur_data[2] = '{8'h00, 8'h00};
  logic [7:0] running = 8'h00;
  logic [7:0] sx_buf[SX_DEPTH];
  int cur_index = 0;
  int cur_len = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] msg_kind(input logic [7:0] s);
    if (s < 8'h80 || s == mbsp_pkg::UNDEF_F4 || s == mbsp_pkg::UNDEF_F5 ||
        s == mbsp_pkg::UNDEF_FD) return mbsp_pkg::NO_MSG;
    if (s < mbsp_pkg::SYSEX_START) return s & 8'hF0;
    return s;
  endfunction

  function automatic logic is_channel(input logic [7:0] s);
    return s >= 8'h80 && s < mbsp_pkg::SYSEX_START;
  endfunction

  function automatic logic is_sx(input logic [7:0] s);
    return s == mbsp_pkg::SYSEX_START || s == mbsp_pkg::SYSEX_END;
  endfunction

  function automatic int msg_size(input logic [7:0] t);
    case (t)
      mbsp_pkg::PROG_CHANGE, mbsp_pkg::CHAN_PRESS, mbsp_pkg::MTC_QFRAME,
      mbsp_pkg::SONG_SEL: return 2;
      mbsp_pkg::NOTE_OFF, mbsp_pkg::NOTE_ON, mbsp_pkg::POLY_PRESS, mbsp_pkg::CTRL_CHANGE,
      mbsp_pkg::PITCH_BEND, mbsp_pkg::SONG_POS: return 3;
      mbsp_pkg::SYSEX_START, mbsp_pkg::SYSEX_END: return SX_DEPTH;
      default: return 1;
    endcase
  endfunction

  function automatic logic listen_ok(input logic [4:0] ch);
    return listen_ch == mbsp_pkg::OMNI || listen_ch == ch;
  endfunction

  function automatic void add_parsed(input logic [7:0] t, input logic [4:0] ch,
                                     input logic [7:0] d1, input logic [7:0] d2,
                                     input int len, input logic [7:0] sb, input int pos,
                                     input logic fin);
    mbsp_pkg::msg_t m;
    m.msg_type = t;
    m.channel = ch;
    m.data1 = d1;
    m.data2 = d2;
    m.msg_length = 7'(len);
    m.sysex_byte = sb;
    m.sysex_position = 6'(pos);
    m.last = fin;
    parsed_msgs.push_back(m);
  endfunction

  function automatic void flush_sysex(input int count);
    for (int k = 0; k < count && k < SX_DEPTH; k++) begin
      add_parsed(mbsp_pkg::SYSEX_START, 5'd0, 8'h00, 8'h00, count, sx_buf[k], k,
                 k + 1 == count);
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [7:0] t;
    logic [7:0] s;
    logic [7:0] carried;
    logic [4:0] ch;
    logic       chan;
    int         len;
    if (b == mbsp_pkg::UNDEF_FD) return;
    if (cur_index == 0) begin
      cur_status = b;
      if (is_channel(running) && b < 8'h80) begin
        cur_status = running;
        cur_data[0] = b;
        cur_index = 1;
      end
      t = msg_kind(cur_status);
      if (t == mbsp_pkg::NO_MSG) return;
      len = msg_size(t);
      if (len == 1) begin
        cur_len = 0;
        add_parsed(t, 5'd0, 8'h00, 8'h00, 1, 8'h00, 0, 1'b1);
        return;
      end
      cur_len = len;
      if (is_sx(t)) begin
        running = 8'h00;
        sx_buf[0] = t;
      end
      if (cur_index + 1 >= len) begin
        ch = {1'b0, cur_status[3:0]} + 5'd1;
        cur_index = 0;
        cur_len = 0;
        if (listen_ok(ch)) add_parsed(t, ch, cur_data[0], 8'h00, 2, 8'h00, 0, 1'b1);
        return;
      end
      cur_index++;
      return;
    end
    if (b >= 8'h80) begin
      if (b >= TIMING_CLK) begin
        add_parsed(b, 5'd0, 8'h00, 8'h00, 1, 8'h00, 0, 1'b1);
        return;
      end
      if (is_sx(b)) begin
        if (!is_sx(cur_status)) return;
        if (cur_index < SX_DEPTH) sx_buf[cur_index] = b;
        len = (cur_index < SX_DEPTH) ? cur_index + 1 : SX_DEPTH;
        cur_index = 0;
        cur_len = 0;
        running = 8'h00;
        flush_sysex(len);
        return;
      end
    end
    if (is_sx(cur_status)) begin
      if (cur_index < SX_DEPTH) sx_buf[cur_index] = b;
    end else begin
      cur_data[(cur_index - 1) % 2] = b;
    end
    if (cur_index >= cur_len - 1) begin
      if (is_sx(cur_status)) begin
        carried = sx_buf[SX_DEPTH - 1];
        sx_buf[SX_DEPTH - 1] = mbsp_pkg::SYSEX_START;
        flush_sysex(SX_DEPTH);
        sx_buf[0] = mbsp_pkg::SYSEX_END;
        sx_buf[1] = carried;
        cur_index = 2;
        sx_overflows++;
        return;
      end
      s = cur_status;
      t = msg_kind(s);
      chan = is_channel(s);
      ch = chan ? {1'b0, s[3:0]} + 5'd1 : 5'd0;
      len = cur_len;
      cur_index = 0;
      cur_len = 0;
      running = chan ? s : 8'h00;
      if (!chan || listen_ok(ch)) begin
        add_parsed(t, ch, cur_data[0], (len == 3) ? cur_data[1] : 8'h00, len, 8'h00, 0, 1'b1);
      end
      return;
    end
    cur_index++;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued_total++;
  endfunction

  function automatic logic [7:0] pick_realtime();
    logic [7:0] rt;
    rt = TIMING_CLK + 8'($urandom_range(7));
    if (rt == mbsp_pkg::UNDEF_FD) rt = ACTIVE_SENSE;
    return rt;
  endfunction

  function automatic void push_data();
    if ($urandom_range(9) == 0) push_byte(pick_realtime());
    if ($urandom_range(19) == 0) push_byte(8'($urandom_range(255)));
    else push_byte(8'($urandom_range(127)));
  endfunction

  function automatic void queue_sysex(input int n_data, input logic closed);
    push_byte(($urandom_range(9) == 0) ? mbsp_pkg::SYSEX_END : mbsp_pkg::SYSEX_START);
    repeat (n_data) push_data();
    if (closed) begin
      push_byte(($urandom_range(3) == 0) ? mbsp_pkg::SYSEX_START : mbsp_pkg::SYSEX_END);
    end
  endfunction

  function automatic void queue_traffic(input int n_bytes, input logic [4:0] ch_cfg);
    int start;
    int pick;
    int n;
    logic [3:0] nib;
    logic [7:0] st;
    start = queued_total;
    while (queued_total - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if (ch_cfg >= 5'd1 && ch_cfg <= 5'd16 && $urandom_range(1) == 1) nib = 4'(ch_cfg - 5'd1);
        else nib = 4'($urandom_range(15));
        st = {1'b1, 3'($urandom_range(6)), nib};
        n = msg_size({st[7:4], 4'h0}) - 1;
        push_byte(st);
        repeat ($urandom_range(2) + 1) repeat (n) push_data();
      end else if (pick < 57) begin
        st = mbsp_pkg::MTC_QFRAME + 8'($urandom_range(2));
        push_byte(st);
        repeat (msg_size(st) - 1) push_data();
      end else if (pick < 72) begin
        if ($urandom_range(19) == 0) queue_sysex($urandom_range(30, 36), 1'b1);
        else queue_sysex($urandom_range(8), $urandom_range(9) != 0);
      end else if (pick < 80) begin
        push_byte(($urandom_range(4) == 0) ? TUNE_REQ : pick_realtime());
      end else begin
        push_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic queue_directed();
    logic [7:0] seq [0:25];
    seq = '{mbsp_pkg::NOTE_ON, 8'h00, 8'h7F, 8'h05, TIMING_CLK, 8'h06,
            mbsp_pkg::PROG_CHANGE | 8'h0F, mbsp_pkg::NOTE_OFF, mbsp_pkg::UNDEF_FD,
            mbsp_pkg::UNDEF_F4, mbsp_pkg::UNDEF_F5, TUNE_REQ,
            SYS_RESET, mbsp_pkg::SONG_POS, mbsp_pkg::SYSEX_END, 8'h01, 8'h02, 8'h44,
            mbsp_pkg::SONG_SEL, 8'h7F,
            mbsp_pkg::SYSEX_START, 8'h00, SYS_RESET, mbsp_pkg::SYSEX_END,
            mbsp_pkg::SYSEX_END, mbsp_pkg::SYSEX_START};
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || rx_valid || parsed_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_listen(input logic [4:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    listen_ch = v;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        parse_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (!rx_valid || !rx_stall) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : msg_monitor
    mbsp_pkg::msg_t want;
    if (rst) begin
      msg_stall <= 1'b0;
    end else begin
      if (msg_valid && !msg_stall) begin
        if (parsed_msgs.size() == 0) begin
          $display("%0t: unexpected word, msg_type %0h", $time, msg_type);
          fail_count++;
        end else begin
          want = parsed_msgs.pop_front();
          check_field("msg_type", want.msg_type, msg_type);
          check_field("channel", 8'(want.channel), 8'(channel));
          check_field("data1", want.data1, data1);
          check_field("data2", want.data2, data2);
          check_field("msg_length", 8'(want.msg_length), 8'(msg_length));
          check_field("sysex_byte", want.sysex_byte, sysex_byte);
          check_field("sysex_position", 8'(want.sysex_position), 8'(sysex_position));
          check_field("last", 8'(want.last), 8'(last));
          msgs_checked++;
        end
      end
      if (long_hold_on && hold_count < LONG_HOLD_CYCLES) begin
        hold_count <= hold_count + 1;
        msg_stall <= 1'b1;
      end else begin
        msg_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (msg_valid && !msg_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("midi_byte_stream_parser verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_listen(mbsp_pkg::OMNI);
    queue_directed();
    wait_idle();

    write_listen(5'd5);
    set_idling(0, 0);
    queue_traffic(12, 5'd5);
    wait_idle();

    write_listen(5'd16);
    set_idling(73, 0);
    queue_traffic(8, 5'd16);
    wait_idle();
    queue_traffic(8, 5'd16);
    wait_idle();

    write_listen(mbsp_pkg::OMNI);
    set_idling(0, 73);
    long_hold_on <= 1'b1;
    queue_sysex(33, 1'b1);
    queue_traffic(4, mbsp_pkg::OMNI);
    wait_idle();
    long_hold_on <= 1'b0;

    write_listen(5'd31);
    set_idling(36, 36);
    queue_traffic(10, 5'd31);
    wait_idle();

    write_listen(5'd1);
    set_idling(0, 0);
    queue_traffic(8, 5'd1);
    wait_idle();

    $display("Sent %0d bytes, checked %0d result words, %0d SysEx overflow chunks.",
             bytes_taken, msgs_checked, sx_overflows);
    $display("Channel filter omni, 5, 16, 31 and 1 under sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("midi_byte_stream_parser verification clean");
    end else begin
      $display("midi_byte_stream_parser verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mbsp_pkg.sv
rtl/mbsp_ram.sv
rtl/midi_byte_stream_parser.sv
tb/sv/midi_byte_stream_parser_test.sv
